// ----- src/arqe_pkg.sv -----
// ---------------------------------------------------------------------------
// arqe_pkg: shared types and helpers for the active rectangle query engine
// Command codes, register indexes, controller states and the control and
// status words between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package arqe_pkg;

  localparam int MAX_RECTS_DEF = 32;

  // command codes
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SPAN  = 3'd2,
    CMD_BOX   = 3'd3,
    CMD_BAND  = 3'd4
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GATE_WIDTH   = 3'd0,
    REG_GATE_EXT     = 3'd1,
    REG_FIN_STEP     = 3'd2,
    REG_Y_OFFSET     = 3'd3,
    REG_COL_ORIGIN   = 3'd4,
    REG_COL_UNIT     = 3'd5,
    REG_CELL_HT      = 3'd6
  } cfg_reg_t;

  // per-entry operation of a table scan
  typedef enum logic [2:0] {
    OP_SPAN,
    OP_EDGE,
    OP_SLAB,
    OP_FIND,
    OP_GROW
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_MUL,
    S_ADD_P,
    S_ADD_N,
    S_SPAN,
    S_BOX_EDGE,
    S_BOX_SLAB,
    S_BAND_FIND,
    S_BAND_GROW,
    S_EMIT
  } state_t;

  // one stored rectangle, x doubled
  typedef struct packed {
    logic [19:0] l2;
    logic [19:0] bot;
    logic [19:0] r2;
    logic [19:0] top;
  } rect_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_table;
    logic add_mul;
    logic push_p;
    logic push_n;
    logic scan_go;
    op_t  op;
    logic edge_init;
    logic advance;
    logic slab_init;
    logic set_cover;
    logic emit;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       pass_done;
    logic       has;
    logic       grew;
    logic       found;
    logic       box_empty;
    logic       reach_ok;
  } stat_t;

  function automatic logic signed [19:0] sat20(input logic signed [27:0] v);
    logic signed [19:0] r;
    if (v < -28'sd524288) r = -20'sd524288;
    else if (v > 28'sd524287) r = 20'sd524287;
    else r = v[19:0];
    return r;
  endfunction

  function automatic logic signed [16:0] clamp17(input logic signed [19:0] v);
    logic signed [16:0] r;
    if (v < -20'sd65536) r = -17'sd65536;
    else if (v > 20'sd65535) r = 17'sd65535;
    else r = v[16:0];
    return r;
  endfunction

endpackage

// ----- src/arqe_ctrl.sv -----
// ---------------------------------------------------------------------------
// arqe_ctrl: command sequencer
// Walks each command through its table scans and issues datapath commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arqe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  arqe_pkg::stat_t stat,
  output arqe_pkg::ctrl_t ctrl
);

  arqe_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arqe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != arqe_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.op = arqe_pkg::OP_SPAN;
    unique case (state)
      arqe_pkg::S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_next = arqe_pkg::S_DECODE;
        end
      end
      arqe_pkg::S_DECODE: begin
        unique case (stat.cmd)
          arqe_pkg::CMD_CLEAR: begin
            ctrl.clr_table = 1'b1;
            state_next = arqe_pkg::S_EMIT;
          end
          arqe_pkg::CMD_ADD: begin
            state_next = arqe_pkg::S_ADD_MUL;
          end
          arqe_pkg::CMD_SPAN: begin
            ctrl.scan_go = 1'b1;
            ctrl.op = arqe_pkg::OP_SPAN;
            state_next = arqe_pkg::S_SPAN;
          end
          arqe_pkg::CMD_BOX: begin
            if (stat.box_empty) begin
              ctrl.set_cover = 1'b1;
              state_next = arqe_pkg::S_EMIT;
            end else begin
              ctrl.edge_init = 1'b1;
              ctrl.scan_go = 1'b1;
              ctrl.op = arqe_pkg::OP_EDGE;
              state_next = arqe_pkg::S_BOX_EDGE;
            end
          end
          arqe_pkg::CMD_BAND: begin
            ctrl.scan_go = 1'b1;
            ctrl.op = arqe_pkg::OP_FIND;
            state_next = arqe_pkg::S_BAND_FIND;
          end
          default: begin
            state_next = arqe_pkg::S_EMIT;
          end
        endcase
      end
      arqe_pkg::S_ADD_MUL: begin
        ctrl.add_mul = 1'b1;
        state_next = arqe_pkg::S_ADD_P;
      end
      arqe_pkg::S_ADD_P: begin
        ctrl.push_p = 1'b1;
        state_next = arqe_pkg::S_ADD_N;
      end
      arqe_pkg::S_ADD_N: begin
        ctrl.push_n = 1'b1;
        state_next = arqe_pkg::S_EMIT;
      end
      arqe_pkg::S_SPAN: begin
        ctrl.op = arqe_pkg::OP_SPAN;
        if (stat.pass_done) state_next = arqe_pkg::S_EMIT;
      end
      arqe_pkg::S_BOX_EDGE: begin
        ctrl.op = arqe_pkg::OP_EDGE;
        if (stat.pass_done) begin
          if (!stat.has) begin
            // no slab left: every slab was covered
            ctrl.set_cover = 1'b1;
            state_next = arqe_pkg::S_EMIT;
          end else begin
            ctrl.slab_init = 1'b1;
            ctrl.scan_go = 1'b1;
            ctrl.op = arqe_pkg::OP_SLAB;
            state_next = arqe_pkg::S_BOX_SLAB;
          end
        end
      end
      arqe_pkg::S_BOX_SLAB: begin
        ctrl.op = arqe_pkg::OP_SLAB;
        if (stat.pass_done) begin
          if (stat.grew) begin
            ctrl.scan_go = 1'b1;
          end else if (stat.reach_ok) begin
            ctrl.advance = 1'b1;
            ctrl.edge_init = 1'b1;
            ctrl.scan_go = 1'b1;
            ctrl.op = arqe_pkg::OP_EDGE;
            state_next = arqe_pkg::S_BOX_EDGE;
          end else begin
            state_next = arqe_pkg::S_EMIT;
          end
        end
      end
      arqe_pkg::S_BAND_FIND: begin
        ctrl.op = arqe_pkg::OP_FIND;
        if (stat.pass_done) begin
          if (stat.found) begin
            ctrl.scan_go = 1'b1;
            ctrl.op = arqe_pkg::OP_GROW;
            state_next = arqe_pkg::S_BAND_GROW;
          end else begin
            state_next = arqe_pkg::S_EMIT;
          end
        end
      end
      arqe_pkg::S_BAND_GROW: begin
        ctrl.op = arqe_pkg::OP_GROW;
        if (stat.pass_done) begin
          if (stat.grew) ctrl.scan_go = 1'b1;
          else state_next = arqe_pkg::S_EMIT;
        end
      end
      arqe_pkg::S_EMIT: begin
        ctrl.emit = 1'b1;
        state_next = arqe_pkg::S_IDLE;
      end
      default: begin
        state_next = arqe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/arqe_dp.sv -----
// ---------------------------------------------------------------------------
// arqe_dp: rectangle table and query datapath
// Config registers, rectangle memory, table scan unit, accumulators and
// result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arqe_dp #(
  parameter int MAX_RECTS = arqe_pkg::MAX_RECTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         command,
  input  logic [7:0]         column,
  input  logic [3:0]         p_fin_count,
  input  logic [3:0]         n_fin_count,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic [15:0]        extent_x,
  input  logic [15:0]        extent_y,
  input  arqe_pkg::ctrl_t    ctrl,
  output arqe_pkg::stat_t    stat,
  output logic               done,
  output logic               answer_flag,
  output logic               band_found,
  output logic signed [16:0] band_bottom,
  output logic signed [16:0] band_top,
  output logic               table_overflow
);

  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  // configuration registers
  logic [15:0] gate_width, gate_ext, fin_step, y_offset, col_unit, cell_ht;
  logic signed [15:0] col_origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_width  <= '0;
      gate_ext    <= '0;
      fin_step    <= '0;
      y_offset    <= '0;
      col_origin  <= '0;
      col_unit    <= '0;
      cell_ht     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arqe_pkg::REG_GATE_WIDTH:  gate_width  <= cfg_data;
        arqe_pkg::REG_GATE_EXT:    gate_ext    <= cfg_data;
        arqe_pkg::REG_FIN_STEP:    fin_step    <= cfg_data;
        arqe_pkg::REG_Y_OFFSET:    y_offset    <= cfg_data;
        arqe_pkg::REG_COL_ORIGIN:  col_origin  <= cfg_data;
        arqe_pkg::REG_COL_UNIT:    col_unit    <= cfg_data;
        arqe_pkg::REG_CELL_HT:     cell_ht     <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched command operands
  logic [2:0]         cmd_q;
  logic [7:0]         col_q;
  logic [3:0]         pc_q, nc_q;
  logic signed [21:0] lx, ux, ly, uy;
  logic signed [19:0] a_q, b_q, y0_q, y1_q;
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [19:0] a_in, b_in;

  assign mnx  = (start_x < end_x) ? start_x : end_x;
  assign mxx  = (start_x < end_x) ? end_x : start_x;
  assign mny  = (start_y < end_y) ? start_y : end_y;
  assign mxy  = (start_y < end_y) ? end_y : start_y;
  assign a_in = $signed({{3{start_x[15]}}, start_x, 1'b0});
  assign b_in = $signed({{3{end_x[15]}}, end_x, 1'b0});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= command;
      col_q <= column;
      pc_q  <= p_fin_count;
      nc_q  <= n_fin_count;
      lx    <= $signed({{5{mnx[15]}}, mnx, 1'b0}) - $signed({6'b0, extent_x});
      ux    <= $signed({{5{mxx[15]}}, mxx, 1'b0}) + $signed({6'b0, extent_x});
      ly    <= $signed({{5{mny[15]}}, mny, 1'b0}) - $signed({6'b0, extent_y});
      uy    <= $signed({{5{mxy[15]}}, mxy, 1'b0}) + $signed({6'b0, extent_y});
      a_q   <= a_in;
      b_q   <= b_in;
      y0_q  <= $signed({{4{start_y[15]}}, start_y});
      y1_q  <= $signed({{4{end_y[15]}}, end_y});
    end
  end

  // add-column products, registered before use
  logic [23:0] prod_cu;
  logic [19:0] prod_p, prod_n;

  always_ff @(posedge clk) begin
    if (ctrl.add_mul) begin
      prod_cu <= col_q * col_unit;
      prod_p  <= 20'(fin_step) * 20'(pc_q);
      prod_n  <= 20'(fin_step) * 20'(nc_q);
    end
  end

  // rectangle geometry for the push cycles
  logic signed [27:0] c2, half, ptop;
  logic [19:0]        l2_w, r2_w;
  logic [19:0]        bot_w, top_w;
  logic               push, full, wr_en;
  logic [CW-1:0]      count;
  logic               overflow;

  always_comb begin
    c2   = ($signed({{12{col_origin[15]}}, col_origin}) + $signed({4'b0, prod_cu})) <<< 1;
    half = $signed({12'b0, gate_width}) + $signed({11'b0, gate_ext, 1'b0});
    ptop = $signed({12'b0, cell_ht}) - $signed({12'b0, y_offset});
    l2_w = arqe_pkg::sat20(c2 - half);
    r2_w = arqe_pkg::sat20(c2 + half);
    if (ctrl.push_p) begin
      bot_w = arqe_pkg::sat20(ptop - $signed({8'b0, prod_p}));
      top_w = arqe_pkg::sat20(ptop);
    end else begin
      bot_w = arqe_pkg::sat20($signed({12'b0, y_offset}));
      top_w = arqe_pkg::sat20($signed({12'b0, y_offset}) + $signed({8'b0, prod_n}));
    end
  end

  assign push  = (ctrl.push_p && (prod_p != '0)) || (ctrl.push_n && (prod_n != '0));
  assign full  = (count >= CW'(MAX_RECTS));
  assign wr_en = push && !full;

  // fill count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctrl.clr_table) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (push) begin
      if (full) overflow <= 1'b1;
      else count <= count + 1'b1;
    end
  end

  // table scan: one entry read per cycle, data in the next cycle
  arqe_pkg::rect_t mem [MAX_RECTS];
  arqe_pkg::rect_t rdata;
  arqe_pkg::op_t   op_q;
  logic            scanning, rvalid, issuing, pass_done;
  logic [CW-1:0]   rd_idx;

  assign issuing   = scanning && (rd_idx < count);
  assign pass_done = scanning && !issuing && !rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IW-1:0]] <= '{l2: l2_w, bot: bot_w, r2: r2_w, top: top_w};
    if (issuing) rdata <= mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      rvalid   <= 1'b0;
    end else begin
      rvalid <= issuing;
      if (ctrl.scan_go) begin
        scanning <= 1'b1;
        rd_idx   <= '0;
        op_q     <= ctrl.op;
      end else if (pass_done) begin
        scanning <= 1'b0;
      end else if (issuing) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // accumulators
  logic               result_flag, found, grew, has;
  logic signed [19:0] lo, hi, cur, nxt, reach;
  logic               result_flag_next, found_next, grew_next, has_next;
  logic signed [19:0] lo_next, hi_next, cur_next, nxt_next, reach_next;

  always_comb begin
    logic signed [19:0] rl, rb, rr, rt, base, px;
    logic               hit;
    rl = $signed(rdata.l2);
    rb = $signed(rdata.bot);
    rr = $signed(rdata.r2);
    rt = $signed(rdata.top);
    px = a_q;
    result_flag_next = result_flag;
    found_next = found;
    grew_next  = grew;
    has_next   = has;
    lo_next    = lo;
    hi_next    = hi;
    cur_next   = cur;
    nxt_next   = nxt;
    reach_next = reach;
    base       = ctrl.advance ? nxt : cur;
    hit = (lx < $signed({{2{rr[19]}}, rr})) && (ux > $signed({{2{rl[19]}}, rl})) &&
          (ly < $signed({rt[19], rt, 1'b0})) && (uy > $signed({rb[19], rb, 1'b0}));

    if (ctrl.load) begin
      result_flag_next = 1'b0;
      found_next = 1'b0;
      lo_next    = '0;
      hi_next    = '0;
      cur_next   = (a_in < b_in) ? a_in : b_in;
    end
    if (ctrl.scan_go) grew_next = 1'b0;
    if (ctrl.advance) cur_next = nxt;
    // box ends are always edge candidates
    if (ctrl.edge_init) begin
      has_next = 1'b0;
      nxt_next = '0;
      if (a_q > base) begin
        nxt_next = a_q;
        has_next = 1'b1;
      end
      if (b_q > base && (!has_next || b_q < nxt_next)) begin
        nxt_next = b_q;
        has_next = 1'b1;
      end
    end
    if (ctrl.slab_init) reach_next = y0_q;
    if (ctrl.set_cover) result_flag_next = 1'b1;

    if (rvalid) begin
      unique case (op_q)
        arqe_pkg::OP_SPAN: begin
          if (hit) result_flag_next = 1'b1;
        end
        arqe_pkg::OP_EDGE: begin
          // smallest rectangle edge inside the box above the current edge
          if (rl > a_q && rl < b_q && rl > cur && (!has_next || rl < nxt_next)) begin
            nxt_next = rl;
            has_next = 1'b1;
          end
          if (rr > a_q && rr < b_q && rr > cur && (!has_next || rr < nxt_next)) begin
            nxt_next = rr;
            has_next = 1'b1;
          end
        end
        arqe_pkg::OP_SLAB: begin
          if (rl <= cur && rr >= nxt && rb <= reach && rt > reach) begin
            reach_next = rt;
            grew_next  = 1'b1;
          end
        end
        arqe_pkg::OP_FIND: begin
          if (rl <= px && px <= rr && rb <= y0_q && y0_q <= rt) begin
            if (!found || rb < lo) lo_next = rb;
            if (!found || rt > hi) hi_next = rt;
            found_next = 1'b1;
          end
        end
        arqe_pkg::OP_GROW: begin
          if (rl <= px && px <= rr && rb <= hi && rt >= lo) begin
            if (rb < lo) begin
              lo_next   = rb;
              grew_next = 1'b1;
            end
            if (rt > hi) begin
              hi_next   = rt;
              grew_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_flag <= 1'b0;
      found       <= 1'b0;
      grew        <= 1'b0;
      has         <= 1'b0;
    end else begin
      result_flag <= result_flag_next;
      found       <= found_next;
      grew        <= grew_next;
      has         <= has_next;
    end
    lo    <= lo_next;
    hi    <= hi_next;
    cur   <= cur_next;
    nxt   <= nxt_next;
    reach <= reach_next;
  end

  // status to the controller
  assign stat.cmd       = cmd_q;
  assign stat.pass_done = pass_done;
  assign stat.has       = has;
  assign stat.grew      = grew;
  assign stat.found     = found;
  assign stat.box_empty = (a_q == b_q);
  assign stat.reach_ok  = (reach >= y1_q);

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
    if (ctrl.emit) begin
      answer_flag    <= result_flag;
      band_found     <= found;
      band_bottom    <= found ? arqe_pkg::clamp17(lo) : '0;
      band_top       <= found ? arqe_pkg::clamp17(hi) : '0;
      table_overflow <= overflow;
    end
  end

endmodule

// ----- src/active_rectangle_query_engine_top.sv -----
// Clear, unused codes and an empty box go straight to the result; add column
// computes its products, then pushes the p and then the n rectangle; span takes one
// table pass; band lookup a find pass and then grow passes; box coverage an edge pass
// and the slab passes for each slab.
// One command in work at a time; result word shown one cycle with done, no stall.
// Sync reset empties the table, clears overflow and zeroes all config registers.
// ---------------------------------------------------------------------------
// active_rectangle_query_engine_top: active rectangle table and queries
// Controller and datapath; command port, config write port, result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module active_rectangle_query_engine_top #(
  parameter int MAX_RECTS = arqe_pkg::MAX_RECTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         command,
  input  logic [7:0]         column,
  input  logic [3:0]         p_fin_count,
  input  logic [3:0]         n_fin_count,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic [15:0]        extent_x,
  input  logic [15:0]        extent_y,
  output logic               done,
  output logic               answer_flag,
  output logic               band_found,
  output logic signed [16:0] band_bottom,
  output logic signed [16:0] band_top,
  output logic               table_overflow
);

  arqe_pkg::ctrl_t ctrl;
  arqe_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  arqe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  arqe_dp #(
    .MAX_RECTS (MAX_RECTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .column         (column),
    .p_fin_count    (p_fin_count),
    .n_fin_count    (n_fin_count),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .extent_x       (extent_x),
    .extent_y       (extent_y),
    .ctrl           (ctrl),
    .stat           (stat),
    .done           (done),
    .answer_flag    (answer_flag),
    .band_found     (band_found),
    .band_bottom    (band_bottom),
    .band_top       (band_top),
    .table_overflow (table_overflow)
  );

endmodule

// ----- sim/active_rectangle_query_engine_top_tb.sv -----
// ---------------------------------------------------------------------------
// active_rectangle_query_engine_top_tb: self-checking bench for the engine
// Drives clear, add-column and query words through the command port, shadows
// the rectangle table in a scoreboard and checks every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module active_rectangle_query_engine_top_tb;

  localparam int TABLE_DEPTH = 32;
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  // one command word
  typedef struct {
    logic [2:0]         cmd;
    logic [7:0]         col;
    logic [3:0]         pcnt;
    logic [3:0]         ncnt;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [15:0]        wx;
    logic [15:0]        wy;
  } cmd_word_t;

  // one result word
  typedef struct {
    logic               flag;
    logic               found;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic               ovf;
  } answer_t;

  // table shadow and expected answers
  class rect_table_sb;
    logic [15:0] regs [7];
    longint      l2 [TABLE_DEPTH];
    longint      bot [TABLE_DEPTH];
    longint      r2 [TABLE_DEPTH];
    longint      top [TABLE_DEPTH];
    int          cnt;
    bit          ovf;
    answer_t     pending [$];
    int          errors;
    int          n_cmd [8];
    int          n_hits;
    int          n_ovf;

    function void wipe();
      cnt = 0;
      ovf = 0;
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void store(longint a, longint b, longint c, longint d);
      if (cnt >= TABLE_DEPTH) begin
        ovf = 1;
        return;
      end
      l2[cnt] = lim(a, -524288, 524287);
      bot[cnt] = lim(b, -524288, 524287);
      r2[cnt] = lim(c, -524288, 524287);
      top[cnt] = lim(d, -524288, 524287);
      cnt++;
    endfunction

    function bit slab_ok(longint a, longint b, longint y0, longint y1);
      longint reach;
      bit grew;
      reach = y0;
      grew = 1;
      while (grew) begin
        grew = 0;
        for (int i = 0; i < cnt; i++)
          if (l2[i] <= a && r2[i] >= b && bot[i] <= reach && top[i] > reach) begin
            reach = top[i];
            grew = 1;
          end
      end
      return reach >= y1;
    endfunction

    function bit covered(longint x0, longint y0, longint x1, longint y1);
      longint edges [$];
      longint a, b, nxt;
      bit has;
      a = 2 * x0;
      b = 2 * x1;
      edges = {edges, a};
      edges = {edges, b};
      for (int i = 0; i < cnt; i++) begin
        if (l2[i] > a && l2[i] < b) edges = {edges, l2[i]};
        if (r2[i] > a && r2[i] < b) edges = {edges, r2[i]};
      end
      foreach (edges[i]) begin
        has = 0;
        nxt = 0;
        foreach (edges[j])
          if (edges[j] > edges[i] && (!has || edges[j] < nxt)) begin
            nxt = edges[j];
            has = 1;
          end
        if (has && !slab_ok(edges[i], nxt, y0, y1)) return 0;
      end
      return 1;
    endfunction

    // merged vertical band at a point
    function bit band(longint x, longint y, output longint lo, output longint hi);
      longint x2;
      bit found, grew;
      x2 = 2 * x;
      found = 0;
      lo = 0;
      hi = 0;
      for (int i = 0; i < cnt; i++)
        if (l2[i] <= x2 && x2 <= r2[i] && bot[i] <= y && y <= top[i]) begin
          if (!found || bot[i] < lo) lo = bot[i];
          if (!found || top[i] > hi) hi = top[i];
          found = 1;
        end
      if (!found) return 0;
      grew = 1;
      while (grew) begin
        grew = 0;
        for (int i = 0; i < cnt; i++)
          if (l2[i] <= x2 && x2 <= r2[i] && bot[i] <= hi && top[i] >= lo) begin
            if (bot[i] < lo) begin lo = bot[i]; grew = 1; end
            if (top[i] > hi) begin hi = top[i]; grew = 1; end
          end
      end
      return 1;
    endfunction

    // accepted command: update shadow, queue the answer
    function void note_cmd(cmd_word_t w);
      answer_t r;
      longint c2, half, ptop, lo, hi, lx, ux, ly, uy;
      longint sx, sy, ex, ey;
      r = '{1'b0, 1'b0, '0, '0, 1'b0};
      sx = longint'(w.sx); sy = longint'(w.sy); ex = longint'(w.ex); ey = longint'(w.ey);
      n_cmd[w.cmd]++;
      case (w.cmd)
        arqe_pkg::CMD_CLEAR: begin
          cnt = 0;
          ovf = 0;
        end
        arqe_pkg::CMD_ADD: begin
          c2 = 2 * (longint'($signed(regs[arqe_pkg::REG_COL_ORIGIN])) +
                    longint'(w.col) * longint'(regs[arqe_pkg::REG_COL_UNIT]));
          half = longint'(regs[arqe_pkg::REG_GATE_WIDTH]) +
                 2 * longint'(regs[arqe_pkg::REG_GATE_EXT]);
          ptop = longint'(regs[arqe_pkg::REG_CELL_HT]) -
                 longint'(regs[arqe_pkg::REG_Y_OFFSET]);
          if (regs[arqe_pkg::REG_FIN_STEP] != 0 && w.pcnt != 0)
            store(c2 - half,
                  ptop - longint'(regs[arqe_pkg::REG_FIN_STEP]) * longint'(w.pcnt),
                  c2 + half, ptop);
          if (regs[arqe_pkg::REG_FIN_STEP] != 0 && w.ncnt != 0)
            store(c2 - half, longint'(regs[arqe_pkg::REG_Y_OFFSET]), c2 + half,
                  longint'(regs[arqe_pkg::REG_Y_OFFSET]) +
                  longint'(regs[arqe_pkg::REG_FIN_STEP]) * longint'(w.ncnt));
        end
        arqe_pkg::CMD_SPAN: begin
          lx = 2 * (sx < ex ? sx : ex) - longint'(w.wx);
          ux = 2 * (sx < ex ? ex : sx) + longint'(w.wx);
          ly = 2 * (sy < ey ? sy : ey) - longint'(w.wy);
          uy = 2 * (sy < ey ? ey : sy) + longint'(w.wy);
          for (int i = 0; i < cnt; i++)
            if (lx < r2[i] && ux > l2[i] && ly < 2 * top[i] && uy > 2 * bot[i])
              r.flag = 1'b1;
        end
        arqe_pkg::CMD_BOX: r.flag = covered(sx, sy, ex, ey);
        arqe_pkg::CMD_BAND: begin
          if (band(sx, sy, lo, hi)) begin
            r.found = 1'b1;
            r.lo = 17'(lim(lo, -65536, 65535));
            r.hi = 17'(lim(hi, -65536, 65535));
          end
        end
        default: ;
      endcase
      r.ovf = ovf;
      if (r.flag || r.found) n_hits++;
      if (ovf) n_ovf++;
      pending.insert(pending.size(), r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.flag !== want.flag)
        report_mismatch("answer_flag", longint'(got.flag), longint'(want.flag));
      if (got.found !== want.found)
        report_mismatch("band_found", longint'(got.found), longint'(want.found));
      if (got.lo !== want.lo)
        report_mismatch("band_bottom", longint'(got.lo), longint'(want.lo));
      if (got.hi !== want.hi)
        report_mismatch("band_top", longint'(got.hi), longint'(want.hi));
      if (got.ovf !== want.ovf)
        report_mismatch("table_overflow", longint'(got.ovf), longint'(want.ovf));
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic [2:0]         command = '0;
  logic [7:0]         column = '0;
  logic [3:0]         p_fin_count = '0;
  logic [3:0]         n_fin_count = '0;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic [15:0]        extent_x = '0;
  logic [15:0]        extent_y = '0;
  logic               done;
  logic               answer_flag;
  logic               band_found;
  logic signed [16:0] band_bottom;
  logic signed [16:0] band_top;
  logic               table_overflow;

  rect_table_sb sb = new();
  int send_idle_pct;

  active_rectangle_query_engine_top dut (.*);

  always #10 clk = ~clk;

  // result words cannot be stalled: take every strobe
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_answer('{answer_flag, band_found, band_bottom, band_top, table_overflow});
  end

  // hand one command word over, then maybe idle
  task send_cmd(cmd_word_t w);
    command <= w.cmd;
    column <= w.col;
    p_fin_count <= w.pcnt;
    n_fin_count <= w.ncnt;
    start_x <= w.sx;
    start_y <= w.sy;
    end_x <= w.ex;
    end_y <= w.ey;
    extent_x <= w.wx;
    extent_y <= w.wy;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_cmd(w);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // let the engine drain before touching config
  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(arqe_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.regs[idx] = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // kind 0 typical small geometry, 1 all max, 2 all min
  task load_config(int kind);
    drain();
    case (kind)
      1: begin
        write_reg(arqe_pkg::REG_GATE_WIDTH, 16'hFFFF);
        write_reg(arqe_pkg::REG_GATE_EXT, 16'hFFFF);
        write_reg(arqe_pkg::REG_FIN_STEP, 16'hFFFF);
        write_reg(arqe_pkg::REG_Y_OFFSET, 16'hFFFF);
        write_reg(arqe_pkg::REG_COL_ORIGIN, 16'h7FFF);
        write_reg(arqe_pkg::REG_COL_UNIT, 16'hFFFF);
        write_reg(arqe_pkg::REG_CELL_HT, 16'hFFFF);
      end
      2: begin
        write_reg(arqe_pkg::REG_GATE_WIDTH, 16'h0);
        write_reg(arqe_pkg::REG_GATE_EXT, 16'h0);
        write_reg(arqe_pkg::REG_FIN_STEP, 16'h0);
        write_reg(arqe_pkg::REG_Y_OFFSET, 16'h0);
        write_reg(arqe_pkg::REG_COL_ORIGIN, 16'h8000);
        write_reg(arqe_pkg::REG_COL_UNIT, 16'h0);
        write_reg(arqe_pkg::REG_CELL_HT, 16'h0);
      end
      default: begin
        write_reg(arqe_pkg::REG_GATE_WIDTH, 16'($urandom_range(0, 30)));
        write_reg(arqe_pkg::REG_GATE_EXT, 16'($urandom_range(0, 10)));
        write_reg(arqe_pkg::REG_FIN_STEP, 16'($urandom_range(1, 20)));
        write_reg(arqe_pkg::REG_Y_OFFSET, 16'($urandom_range(0, 30)));
        write_reg(arqe_pkg::REG_COL_ORIGIN, 16'($urandom_range(0, 400)) - 16'd200);
        write_reg(arqe_pkg::REG_COL_UNIT, 16'($urandom_range(0, 40)));
        write_reg(arqe_pkg::REG_CELL_HT, 16'($urandom_range(0, 300)));
      end
    endcase
  endtask

  function cmd_word_t blank(logic [2:0] c);
    cmd_word_t w;
    w = '{c, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    return w;
  endfunction

  // x near a column, y near the active rows
  function logic [15:0] near_x();
    longint v;
    v = longint'($signed(sb.regs[arqe_pkg::REG_COL_ORIGIN])) +
        longint'($urandom_range(0, 15)) * longint'(sb.regs[arqe_pkg::REG_COL_UNIT]) +
        longint'($urandom_range(0, 60)) - 30;
    return v[15:0];
  endfunction

  function logic [15:0] near_y();
    longint v;
    v = longint'($urandom_range(0, sb.regs[arqe_pkg::REG_CELL_HT] + 40)) - 20;
    return v[15:0];
  endfunction

  function cmd_word_t rand_cmd();
    cmd_word_t w;
    int pick;
    pick = $urandom_range(99);
    w = blank(arqe_pkg::CMD_ADD);
    w.col = 8'($urandom_range(0, 15));
    w.pcnt = 4'($urandom);
    w.ncnt = 4'($urandom);
    w.sx = near_x();
    w.sy = near_y();
    w.ex = near_x();
    w.ey = near_y();
    w.wx = 16'($urandom_range(0, 40));
    w.wy = 16'($urandom_range(0, 40));
    if (pick < 3) w.cmd = arqe_pkg::CMD_CLEAR;
    else if (pick < 35) w.cmd = arqe_pkg::CMD_ADD;
    else if (pick < 55) w.cmd = arqe_pkg::CMD_SPAN;
    else if (pick < 75) w.cmd = arqe_pkg::CMD_BOX;
    else if (pick < 95) w.cmd = arqe_pkg::CMD_BAND;
    else if (pick < 97) w.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    else begin
      // full-range noise
      w = '{3'($urandom_range(0, 7)), 8'($urandom), 4'($urandom), 4'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom)};
    end
    if ($urandom_range(9) == 0) w.col = 8'($urandom);
    return w;
  endfunction

  initial begin
    cmd_word_t w;
    sb.wipe();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fixed geometry, special cases
    send_idle_pct = 6;
    write_reg(arqe_pkg::REG_GATE_WIDTH, 16'd10);
    write_reg(arqe_pkg::REG_GATE_EXT, 16'd2);
    write_reg(arqe_pkg::REG_FIN_STEP, 16'd8);
    write_reg(arqe_pkg::REG_Y_OFFSET, 16'd10);
    write_reg(arqe_pkg::REG_COL_ORIGIN, -16'sd100);
    write_reg(arqe_pkg::REG_COL_UNIT, 16'd40);
    write_reg(arqe_pkg::REG_CELL_HT, 16'd200);
    send_cmd(blank(CMD_SPARE_A));
    send_cmd(blank(CMD_SPARE_B));
    send_cmd(blank(CMD_SPARE_C));
    send_cmd(blank(arqe_pkg::CMD_CLEAR));
    w = blank(arqe_pkg::CMD_ADD); w.pcnt = 4'hF; w.ncnt = 4'hF; send_cmd(w);
    w = blank(arqe_pkg::CMD_ADD); w.col = 8'hFF; send_cmd(w);
    w = blank(arqe_pkg::CMD_ADD); w.col = 8'd3; w.pcnt = 4'd1; send_cmd(w);
    w = blank(arqe_pkg::CMD_SPAN); w.sx = -16'sd32768; w.ex = 16'sd32767;
    w.sy = -16'sd32768; w.ey = 16'sd32767; w.wx = 16'hFFFF; w.wy = 16'hFFFF; send_cmd(w);
    w = blank(arqe_pkg::CMD_SPAN); w.sx = 16'sd500; w.ex = 16'sd600; send_cmd(w);
    w = blank(arqe_pkg::CMD_BOX); w.sx = 16'sd5; w.ex = 16'sd5; w.sy = '0;
    w.ey = 16'sd100; send_cmd(w);
    w = blank(arqe_pkg::CMD_BOX); w.sx = -16'sd97; w.ex = -16'sd103; w.sy = 16'sd20;
    w.ey = 16'sd60; send_cmd(w);
    w = blank(arqe_pkg::CMD_BOX); w.sx = -16'sd2000; w.ex = 16'sd2000; w.sy = 16'sd50;
    w.ey = 16'sd50; send_cmd(w);
    w = blank(arqe_pkg::CMD_BOX); w.sx = -16'sd102; w.ex = -16'sd98; w.sy = 16'sd10;
    w.ey = 16'sd130; send_cmd(w);
    w = blank(arqe_pkg::CMD_BAND); w.sx = -16'sd100; w.sy = 16'sd10; send_cmd(w);
    w = blank(arqe_pkg::CMD_BAND); w.sx = 16'sd900; w.sy = 16'sd10; send_cmd(w);
    // fill past the table depth
    for (int i = 0; i < 15; i++) begin
      w = blank(arqe_pkg::CMD_ADD); w.col = 8'(i); w.pcnt = 4'hF; w.ncnt = 4'hF;
      send_cmd(w);
    end
    send_cmd(blank(arqe_pkg::CMD_BAND));
    send_cmd(blank(arqe_pkg::CMD_CLEAR));

    // random phases; sender idling light, heavy, then none
    for (int ph = 0; ph < 6; ph++) begin
      load_config(ph == 1 ? 1 : (ph == 3 ? 2 : 0));
      send_idle_pct = (ph < 2) ? 6 : ((ph < 4) ? 68 : 0);
      for (int n = 0; n < 205; n++) begin
        send_cmd(rand_cmd());
        if (n == 100) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d clears, %0d adds, %0d spans, %0d boxes, %0d bands, %0d spare codes",
             sb.n_cmd[arqe_pkg::CMD_CLEAR], sb.n_cmd[arqe_pkg::CMD_ADD],
             sb.n_cmd[arqe_pkg::CMD_SPAN], sb.n_cmd[arqe_pkg::CMD_BOX],
             sb.n_cmd[arqe_pkg::CMD_BAND], sb.n_cmd[CMD_SPARE_A] + sb.n_cmd[CMD_SPARE_B] +
             sb.n_cmd[CMD_SPARE_C]);
    $display("hits %0d, answers with overflow set %0d", sb.n_hits, sb.n_ovf);
    if (sb.pending.size() != 0) sb.report_mismatch("results missing", 0, sb.pending.size());
    if (sb.errors == 0) begin
      $display("[active_rectangle_query_engine_top] OK");
    end else begin
      $display("[active_rectangle_query_engine_top] ERROR");
    end
    $finish;
  end

  // hang guard, well above the slowest box coverage on a full table every word
  initial begin
    repeat (8) #1_000_000_000;
    $display("[active_rectangle_query_engine_top] ERROR");
    $finish;
  end

endmodule
